// ===== sv/knn_pkg.sv =====
package knn_pkg;

    // Default sizes
    localparam int MAX_TRAIN_POINTS_D = 256;
    localparam int MAX_FEATURES_D     = 16;
    localparam int MAX_NEIGHBOURS_D   = 16;
    localparam int CLASS_COUNT_D      = 10;
    localparam int FEATURE_BITS_D     = 16;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int LABEL_W = 4;
    localparam int CFG_W   = 5;
    localparam int VOTE_OW = 5;

    // Register reset values
    localparam logic [CFG_W-1:0] NEIGHBOURS_RST = 5'd5;
    localparam logic [CFG_W-1:0] FEATURES_RST   = 5'd4;

    // Register indexes
    localparam logic CFG_NEIGHBOURS = 1'b0;
    localparam logic CFG_FEATURES   = 1'b1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TRAIN = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Status codes
    localparam logic ST_PREDICT = 1'b0;
    localparam logic ST_REJECT  = 1'b1;

    // Tag that travels with each feature through the distance pipeline
    typedef struct packed {
        logic v;
        logic first;
        logic last;
    } t_tag;

    // Control of the neighbor chain
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_chain_ctl;

endpackage

// ===== sv/knn_ram.sv =====
module knn_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/knn_dist.sv =====
module knn_dist #(
    parameter int FEATURE_BITS = knn_pkg::FEATURE_BITS_D,
    parameter int DIST_W       = 37,
    parameter int IDX_W        = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  knn_pkg::t_tag           i_tag,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic [FEATURE_BITS-1:0] i_query,
    input  logic [FEATURE_BITS-1:0] i_train,
    output logic                    o_cand_v,
    output logic [DIST_W-1:0]       o_cand_d,
    output logic [IDX_W-1:0]        o_cand_idx,
    output logic                    o_busy
);

    localparam int DIFF_W = FEATURE_BITS + 1;
    localparam int SQ_W   = 2 * FEATURE_BITS;

    knn_pkg::t_tag            r_tag1, r_tag2;
    logic [IDX_W-1:0]         r_idx1, r_idx2, r_cand_idx;
    logic signed [DIFF_W-1:0] r_diff;
    logic [SQ_W-1:0]          r_sq;
    logic [DIST_W-1:0]        r_acc, r_cand_d;
    logic                     r_cand_v;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic [DIST_W-1:0]        w_sum;

    assign w_prod = r_diff * r_diff;
    assign w_sum  = (r_tag2.first ? '0 : r_acc) + DIST_W'(r_sq);

    // Control: tags and candidate valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1   <= '0;
            r_tag2   <= '0;
            r_cand_v <= 1'b0;
        end else begin
            r_tag1   <= i_tag;
            r_tag2   <= r_tag1;
            r_cand_v <= r_tag2.v && r_tag2.last;
        end
    end

    // Datapath: difference, square, running sum
    always_ff @(posedge i_clk) begin
        r_diff <= $signed({i_query[FEATURE_BITS-1], i_query})
                - $signed({i_train[FEATURE_BITS-1], i_train});
        r_idx1 <= i_idx;
        r_sq   <= SQ_W'(w_prod);
        r_idx2 <= r_idx1;
        if (r_tag2.v) begin
            r_acc <= w_sum;
        end
        r_cand_d   <= w_sum;
        r_cand_idx <= r_idx2;
    end

    assign o_cand_v   = r_cand_v;
    assign o_cand_d   = r_cand_d;
    assign o_cand_idx = r_cand_idx;
    assign o_busy     = i_tag.v || r_tag1.v || r_tag2.v || r_cand_v;

endmodule

// ===== sv/knn_cell.sv =====
module knn_cell #(
    parameter int DIST_W = 37,
    parameter int IDX_W  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  knn_pkg::t_chain_ctl i_ctl,
    input  logic                i_en,
    input  logic [DIST_W-1:0]   i_cand_d,
    input  logic [IDX_W-1:0]    i_cand_idx,
    input  logic                i_prev_greater,
    input  logic                i_prev_v,
    input  logic [DIST_W-1:0]   i_prev_d,
    input  logic [IDX_W-1:0]    i_prev_idx,
    input  logic                i_next_v,
    input  logic [IDX_W-1:0]    i_next_idx,
    input  logic [DIST_W-1:0]   i_next_d,
    output logic                o_greater,
    output logic                o_v,
    output logic [DIST_W-1:0]   o_d,
    output logic [IDX_W-1:0]    o_idx
);

    logic              r_v;
    logic [DIST_W-1:0] r_d;
    logic [IDX_W-1:0]  r_idx;

    // An empty cell counts as farther than any candidate
    assign o_greater = !r_v || (r_d > i_cand_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_v <= 1'b0;
        end else if (i_ctl.shift) begin
            r_v <= i_next_v;
        end else if (i_ctl.insert && i_en) begin
            if (i_prev_greater) begin
                r_v <= i_prev_v;
            end else if (o_greater) begin
                r_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_d   <= i_next_d;
            r_idx <= i_next_idx;
        end else if (i_ctl.insert && i_en) begin
            if (i_prev_greater) begin
                r_d   <= i_prev_d;
                r_idx <= i_prev_idx;
            end else if (o_greater) begin
                r_d   <= i_cand_d;
                r_idx <= i_cand_idx;
            end
        end
    end

    assign o_v   = r_v;
    assign o_d   = r_d;
    assign o_idx = r_idx;

endmodule

// ===== sv/knn_classifier.sv =====
// Training and clear beats need no scan; a rejected point's status beat is ready next cycle.
// A query's last feature starts a scan (an empty store goes straight to the drain); the scan
// reads one stored feature per cycle from the single read port of the feature memory.
// Input is not taken during a scan; one item at a time.
// Synchronous active-low reset empties the store and restores k=5, 4 features.
module knn_classifier #(
    parameter int MAX_TRAIN_POINTS = knn_pkg::MAX_TRAIN_POINTS_D,
    parameter int MAX_FEATURES     = knn_pkg::MAX_FEATURES_D,
    parameter int MAX_NEIGHBOURS   = knn_pkg::MAX_NEIGHBOURS_D,
    parameter int CLASS_COUNT      = knn_pkg::CLASS_COUNT_D,
    parameter int FEATURE_BITS     = knn_pkg::FEATURE_BITS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode, feature_value, train_label, zero fill
    input  logic [((knn_pkg::OP_W + FEATURE_BITS + knn_pkg::LABEL_W + 7) / 8) * 8 - 1:0]
                        i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status, class, winning_votes, zero fill
    output logic [15:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [knn_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int FA     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW     = (MAX_TRAIN_POINTS > 1) ? $clog2(MAX_TRAIN_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_TRAIN_POINTS + 1);
    localparam int DIST_W = 2 * FEATURE_BITS + $clog2(MAX_FEATURES) + 1;
    localparam int VW     = $clog2(MAX_NEIGHBOURS + 1);
    localparam int CW     = $clog2(CLASS_COUNT);
    localparam int NC     = MAX_NEIGHBOURS;
    localparam int VCW    = $clog2(MAX_NEIGHBOURS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_VOTE  = 6'b001000,
        S_PICK  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    // Input fields
    logic [knn_pkg::OP_W-1:0]    w_op;
    logic [FEATURE_BITS-1:0]     w_val;
    logic [knn_pkg::LABEL_W-1:0] w_label;
    logic                        w_acc;
    assign w_op    = i_s_axis_tdata[knn_pkg::OP_W-1:0];
    assign w_val   = i_s_axis_tdata[knn_pkg::OP_W +: FEATURE_BITS];
    assign w_label = i_s_axis_tdata[knn_pkg::OP_W + FEATURE_BITS +: knn_pkg::LABEL_W];
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers
    logic [knn_pkg::CFG_W-1:0] r_nc, r_fc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= knn_pkg::NEIGHBOURS_RST;
            r_fc <= knn_pkg::FEATURES_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == knn_pkg::CFG_NEIGHBOURS) begin
                r_nc <= i_cfg_data;
            end else begin
                r_fc <= i_cfg_data;
            end
        end
    end

    // Effective k and feature count
    logic [7:0] w_k, w_nf;
    assign w_k  = ({3'b0, r_nc} > 8'(MAX_NEIGHBOURS)) ? 8'(MAX_NEIGHBOURS) : {3'b0, r_nc};
    assign w_nf = (r_fc == '0) ? 8'd1 :
                  ({3'b0, r_fc} > 8'(MAX_FEATURES)) ? 8'(MAX_FEATURES) : {3'b0, r_fc};

    logic [CNT_W-1:0]          r_count;
    logic [FA-1:0]             r_pos;
    logic [FEATURE_BITS-1:0]   r_query [MAX_FEATURES];
    logic [PW-1:0]             r_p;
    logic [FA-1:0]             r_j;
    logic [FEATURE_BITS-1:0]   r_q;
    knn_pkg::t_tag             r_tag;
    logic [PW-1:0]             r_tag_idx;
    logic                      r_out_v;
    logic [15:0]               r_out;
    logic [VCW-1:0]            r_vc;
    logic                      r_lv;
    logic [VW-1:0]             r_votes [CLASS_COUNT];
    logic [CW-1:0]             r_c;
    logic [CW-1:0]             r_best;
    logic [VW-1:0]             r_bv;

    logic w_last_pos, w_store_ok, w_scan_last_j, w_scan_last_p, w_out_free;
    assign w_last_pos    = (8'(r_pos) + 8'd1) >= w_nf;
    assign w_store_ok    = r_count < CNT_W'(MAX_TRAIN_POINTS);
    assign w_scan_last_j = (8'(r_j) + 8'd1) >= w_nf;
    assign w_scan_last_p = (CNT_W'(r_p) + CNT_W'(1)) >= r_count;
    assign w_out_free    = !r_out_v || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;

    // Feature and label memories
    logic                    w_fwe, w_lwe;
    logic [FEATURE_BITS-1:0] w_train;
    logic [knn_pkg::LABEL_W-1:0] w_lab_rd;
    logic [PW-1:0]           w_lab_raddr;

    assign w_fwe = w_acc && (w_op == knn_pkg::OP_TRAIN) && w_store_ok;
    assign w_lwe = w_fwe && w_last_pos;

    knn_ram #(.WIDTH(FEATURE_BITS), .ADDR_W(PW + FA)) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr ({r_count[PW-1:0], r_pos}),
        .i_wdata (w_val),
        .i_raddr ({r_p, r_j}),
        .o_rdata (w_train)
    );

    knn_ram #(.WIDTH(knn_pkg::LABEL_W), .ADDR_W(PW)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_lwe),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata (w_label),
        .i_raddr (w_lab_raddr),
        .o_rdata (w_lab_rd)
    );

    // Distance pipeline
    logic              w_cand_v, w_busy;
    logic [DIST_W-1:0] w_cand_d;
    logic [PW-1:0]     w_cand_idx;

    knn_dist #(.FEATURE_BITS(FEATURE_BITS), .DIST_W(DIST_W), .IDX_W(PW)) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_tag),
        .i_idx      (r_tag_idx),
        .i_query    (r_q),
        .i_train    (w_train),
        .o_cand_v   (w_cand_v),
        .o_cand_d   (w_cand_d),
        .o_cand_idx (w_cand_idx),
        .o_busy     (w_busy)
    );

    // Neighbor chain, nearest first
    knn_pkg::t_chain_ctl w_ctl;
    logic              w_gt  [NC];
    logic              w_cv  [NC+1];
    logic [DIST_W-1:0] w_cd  [NC+1];
    logic [PW-1:0]     w_ci  [NC+1];

    assign w_ctl.clear  = w_acc && (w_op == knn_pkg::OP_QUERY) && w_last_pos;
    assign w_ctl.insert = w_cand_v;
    assign w_ctl.shift  = (r_state == S_VOTE);
    assign w_cv[NC] = 1'b0;
    assign w_cd[NC] = '0;
    assign w_ci[NC] = '0;

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        logic w_pg, w_pv;
        logic [DIST_W-1:0] w_pd;
        logic [PW-1:0] w_pi;
        if (gi == 0) begin : g_head
            assign w_pg = 1'b0;
            assign w_pv = 1'b0;
            assign w_pd = '0;
            assign w_pi = '0;
        end else begin : g_body
            assign w_pg = w_gt[gi-1];
            assign w_pv = w_cv[gi-1];
            assign w_pd = w_cd[gi-1];
            assign w_pi = w_ci[gi-1];
        end
        knn_cell #(.DIST_W(DIST_W), .IDX_W(PW)) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_en           (8'(gi) < w_k),
            .i_cand_d       (w_cand_d),
            .i_cand_idx     (w_cand_idx),
            .i_prev_greater (w_pg),
            .i_prev_v       (w_pv),
            .i_prev_d       (w_pd),
            .i_prev_idx     (w_pi),
            .i_next_v       (w_cv[gi+1]),
            .i_next_idx     (w_ci[gi+1]),
            .i_next_d       (w_cd[gi+1]),
            .o_greater      (w_gt[gi]),
            .o_v            (w_cv[gi]),
            .o_d            (w_cd[gi]),
            .o_idx          (w_ci[gi])
        );
    end

    assign w_lab_raddr = w_ci[0];

    // Query feature store
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_op == knn_pkg::OP_QUERY)) begin
            r_query[r_pos] <= w_val;
        end
        r_q       <= r_query[r_j];
        r_tag_idx <= r_p;
    end

    // Scan tag, one per stored feature read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (r_state == S_SCAN) begin
            r_tag.v     <= 1'b1;
            r_tag.first <= (r_j == '0);
            r_tag.last  <= w_scan_last_j;
        end else begin
            r_tag <= '0;
        end
    end

    // Output beat valid: set by a reject or a finished vote, cleared when taken
    logic w_out_set;
    assign w_out_set = (w_acc && (w_op == knn_pkg::OP_TRAIN) && w_last_pos && !w_store_ok)
                    || ((r_state == S_DONE) && w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_set) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_p     <= '0;
            r_j     <= '0;
            r_vc    <= '0;
            r_c     <= '0;
            r_best  <= '0;
            r_bv    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && (w_op == knn_pkg::OP_CLEAR)) begin
                        r_count <= '0;
                        r_pos   <= '0;
                    end else if (w_acc && (w_op != knn_pkg::OP_NONE)) begin
                        r_pos <= w_last_pos ? '0 : r_pos + FA'(1);
                        if (w_last_pos && (w_op == knn_pkg::OP_TRAIN)) begin
                            if (w_store_ok) begin
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_out   <= {11'b0, 4'b0, knn_pkg::ST_REJECT};
                            end
                        end else if (w_last_pos) begin
                            r_p     <= '0;
                            r_j     <= '0;
                            r_state <= (r_count == '0) ? S_DRAIN : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_scan_last_j) begin
                        r_j <= '0;
                        r_p <= r_p + PW'(1);
                        if (w_scan_last_p) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + FA'(1);
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_vc    <= '0;
                        r_state <= S_VOTE;
                    end
                end
                S_VOTE: begin
                    if (r_vc == VCW'(MAX_NEIGHBOURS)) begin
                        r_c     <= '0;
                        r_best  <= '0;
                        r_bv    <= '0;
                        r_state <= S_PICK;
                    end else begin
                        r_vc <= r_vc + VCW'(1);
                    end
                end
                S_PICK: begin
                    if (r_votes[r_c] > r_bv) begin
                        r_bv   <= r_votes[r_c];
                        r_best <= r_c;
                    end
                    r_c <= r_c + CW'(1);
                    if (r_c == CW'(CLASS_COUNT - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out   <= {6'b0,
                                    (32'(r_bv) > 32'd31) ? 5'd31 : 5'(r_bv),
                                    4'(r_best), knn_pkg::ST_PREDICT};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Label read of the chain head is valid in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else begin
            r_lv <= (r_state == S_VOTE) && (r_vc != VCW'(MAX_NEIGHBOURS)) && w_cv[0];
        end
    end

    // Vote counters, cleared as the vote starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ((r_state == S_DRAIN) && !w_busy)) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_votes[c] <= '0;
            end
        end else if (r_lv && ({1'b0, w_lab_rd} < 5'(CLASS_COUNT))) begin
            r_votes[w_lab_rd[CW-1:0]] <= r_votes[w_lab_rd[CW-1:0]] + VW'(1);
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out;

    // Checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TRAIN_POINTS))
        else $error("store count above capacity");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("input taken during a scan");

    a_cand_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand_v |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("distance result outside a scan");

    a_vote_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_VOTE) |-> $past(!w_busy))
        else $error("vote started with distances in flight");

endmodule
